// ===== rtl/core/weighted_2d_histogram_fill_macros.svh =====
// assertion macros for the weighted 2d histogram
`ifndef WEIGHTED_2D_HISTOGRAM_FILL_MACROS_SVH
`define WEIGHTED_2D_HISTOGRAM_FILL_MACROS_SVH
`ifndef ASSERT_OFF
`define W2H_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define W2H_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define W2H_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define W2H_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/w2h_pkg.sv =====
// shared types and constants of the weighted 2d histogram
package w2h_pkg;
    localparam logic [1:0] OP_FILL     = 2'd0;
    localparam logic [1:0] OP_READ_BIN = 2'd1;

    localparam logic [2:0] REG_X_LOWER = 3'd0;
    localparam logic [2:0] REG_X_UPPER = 3'd1;
    localparam logic [2:0] REG_X_SCALE = 3'd2;
    localparam logic [2:0] REG_X_BINS  = 3'd3;
    localparam logic [2:0] REG_Y_LOWER = 3'd4;
    localparam logic [2:0] REG_Y_UPPER = 3'd5;
    localparam logic [2:0] REG_Y_SCALE = 3'd6;
    localparam logic [2:0] REG_Y_BINS  = 3'd7;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic bin_calc;
        logic mem_read;
        logic update;
        logic result_load;
    } w2h_cmd_t;

    typedef struct packed {
        logic clear_done;
    } w2h_stat_t;
endpackage

// ===== rtl/core/w2h_ctrl.sv =====
// controller state machine of the weighted 2d histogram
module w2h_ctrl
    import w2h_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output w2h_cmd_t  cmd,
    input  w2h_stat_t stat
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BIN   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       take_in;

    assign s_tready = (state_reg == ST_IDLE);
    assign take_in  = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take_in) begin
                    cmd.load   = 1'b1;
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                cmd.bin_calc = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.result_load = 1'b1;
                    mvalid_next     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// ===== rtl/core/w2h_datapath.sv =====
// binning, bin memory and saturating accumulators
module w2h_datapath
    import w2h_pkg::*;
#(
    parameter int MAX_BINS_X = 62,
    parameter int MAX_BINS_Y = 62,
    parameter int IDX_W      = 12
)(
    input  logic         aclk,
    input  logic         aresetn,
    input  w2h_cmd_t     cmd,
    output w2h_stat_t    stat,
    input  logic [1:0]   in_opcode,
    input  logic [15:0]  in_x,
    input  logic [15:0]  in_y,
    input  logic [15:0]  in_w,
    input  logic [5:0]   in_rx,
    input  logic [5:0]   in_ry,
    input  logic [15:0]  x_lower,
    input  logic [15:0]  x_upper,
    input  logic [23:0]  x_scale,
    input  logic [5:0]   x_bins,
    input  logic [15:0]  y_lower,
    input  logic [15:0]  y_upper,
    input  logic [23:0]  y_scale,
    input  logic [5:0]   y_bins,
    output logic [540:0] m_data
);
    localparam int DEPTH = (MAX_BINS_X + 2) * (MAX_BINS_Y + 2);
    localparam int BW    = $clog2(MAX_BINS_X + 2 > MAX_BINS_Y + 2 ?
                                  MAX_BINS_X + 2 : MAX_BINS_Y + 2) + 1;

    logic [127:0] mem [DEPTH];
    logic [IDX_W-1:0] clr_reg;
    logic             clr_done_reg;

    logic [1:0]  op_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [15:0] w_reg;
    logic [5:0]  rx_reg, ry_reg;
    logic [41:0] px_reg, py_reg;
    logic [BW-1:0] bx_reg, by_reg;
    logic [IDX_W-1:0] idx_reg;
    logic        status_reg, inr_reg;
    logic [127:0] rd_reg;
    logic signed [31:0] xw_reg, yw_reg;
    logic [31:0] w2_reg, xx_reg, yy_reg;

    logic [31:0] ent_reg;
    logic [47:0] gw_reg;
    logic [63:0] gw2_reg, gwxx_reg, gwyy_reg;
    logic signed [63:0] gwx_reg, gwy_reg;

    logic [31:0] bc_res_reg;
    logic [39:0] bw_res_reg;
    logic [55:0] bw2_res_reg;
    logic [IDX_W-1:0] flat_res_reg;
    logic        st_res_reg;

    logic [BW-1:0] nbx, nby;
    logic [BW-1:0] bx_c, by_c;
    logic [IDX_W-1:0] idx_c;
    logic        stat_c;
    logic [31:0] bc_n;
    logic [39:0] bw_n;
    logic [55:0] bw2_n;
    logic [63:0] xxw, yyw;

    assign stat.clear_done = clr_done_reg;

    function automatic logic [BW-1:0] eff_bins(input logic [5:0] r, input int mx);
        logic [BW-1:0] v;
        v = BW'(r);
        if (r == 6'd0) begin
            v = BW'(1);
        end else if (int'(r) > mx) begin
            v = BW'(mx);
        end
        return v;
    endfunction

    function automatic logic [BW-1:0] axis_bin(input logic [41:0] p, input logic [BW-1:0] nb);
        logic signed [26:0] q;
        logic [BW-1:0] b;
        q = 27'($signed(p[41:16])) + 27'sd1;
        if (q < 0) begin
            b = '0;
        end else if (q > $signed({18'd0, nb} + 27'd1)) begin
            b = nb + BW'(1);
        end else begin
            b = q[BW-1:0];
        end
        return b;
    endfunction

    always_comb begin
        nbx  = eff_bins(x_bins, MAX_BINS_X);
        nby  = eff_bins(y_bins, MAX_BINS_Y);
        bx_c = axis_bin(px_reg, nbx);
        by_c = axis_bin(py_reg, nby);
        stat_c = 1'b0;
        if (op_reg == OP_READ_BIN) begin
            bx_c = BW'(rx_reg);
            by_c = BW'(ry_reg);
            stat_c = ({1'b0, rx_reg} > 7'(nbx) + 7'd1) || ({1'b0, ry_reg} > 7'(nby) + 7'd1);
        end
        idx_c = IDX_W'(32'(bx_c) + (32'(nbx) + 32'd2) * 32'(by_c));
        if (32'(idx_c) >= DEPTH) begin
            idx_c = IDX_W'(DEPTH - 1);
        end
    end

    always_comb begin
        bc_n  = (rd_reg[31:0] == '1) ? rd_reg[31:0] : rd_reg[31:0] + 32'd1;
        bw_n  = ({1'b0, rd_reg[71:32]} + 41'(w_reg) > 41'h0FF_FFFF_FFFF) ? '1 :
                rd_reg[71:32] + 40'(w_reg);
        bw2_n = ({1'b0, rd_reg[127:72]} + 57'(w2_reg) > {1'b0, {56{1'b1}}}) ? '1 :
                rd_reg[127:72] + 56'(w2_reg);
        xxw   = 64'(xx_reg) * 64'(w_reg);
        yyw   = 64'(yy_reg) * 64'(w_reg);
    end

    function automatic logic [63:0] sat_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_s64(input logic signed [63:0] a,
                                                   input logic signed [31:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.clear_en && !clr_done_reg) begin
            mem[clr_reg] <= '0;
        end else if (cmd.update && op_reg == OP_FILL) begin
            mem[idx_reg] <= {bw2_n, bw_n, bc_n};
        end
        if (cmd.mem_read) begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end else if (cmd.clear_en && !clr_done_reg) begin
            if (32'(clr_reg) == DEPTH - 1) begin
                clr_done_reg <= 1'b1;
            end
            clr_reg <= clr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_opcode;
            x_reg  <= in_x;
            y_reg  <= in_y;
            w_reg  <= in_w;
            rx_reg <= in_rx;
            ry_reg <= in_ry;
            px_reg <= 42'($signed(17'($signed(in_x)) - 17'($signed(x_lower))))
                      * $signed({18'd0, x_scale});
            py_reg <= 42'($signed(17'($signed(in_y)) - 17'($signed(y_lower))))
                      * $signed({18'd0, y_scale});
        end
        if (cmd.bin_calc) begin
            idx_reg    <= idx_c;
            status_reg <= stat_c;
            inr_reg    <= ($signed(x_reg) >= $signed(x_lower)) &&
                          ($signed(x_reg) <= $signed(x_upper)) &&
                          ($signed(y_reg) >= $signed(y_lower)) &&
                          ($signed(y_reg) <= $signed(y_upper));
            xw_reg <= 32'(x_reg) * $signed({1'b0, w_reg});
            yw_reg <= 32'(y_reg) * $signed({1'b0, w_reg});
            w2_reg <= 32'(w_reg) * 32'(w_reg);
            xx_reg <= 32'(x_reg * x_reg);
            yy_reg <= 32'(y_reg * y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg  <= '0;
            gw_reg   <= '0;
            gw2_reg  <= '0;
            gwx_reg  <= '0;
            gwxx_reg <= '0;
            gwy_reg  <= '0;
            gwyy_reg <= '0;
        end else if (cmd.update && op_reg == OP_FILL) begin
            if (ent_reg != '1) begin
                ent_reg <= ent_reg + 32'd1;
            end
            if (inr_reg) begin
                gw_reg   <= ({1'b0, gw_reg} + 49'(w_reg) > 49'h0FFFF_FFFF_FFFF) ? '1 :
                            gw_reg + 48'(w_reg);
                gw2_reg  <= sat_u64(gw2_reg, 64'(w2_reg));
                gwx_reg  <= sat_s64(gwx_reg, xw_reg);
                gwy_reg  <= sat_s64(gwy_reg, yw_reg);
                gwxx_reg <= sat_u64(gwxx_reg, xxw);
                gwyy_reg <= sat_u64(gwyy_reg, yyw);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            flat_res_reg <= '0;
            st_res_reg   <= 1'b0;
            bc_res_reg   <= '0;
            bw_res_reg   <= '0;
            bw2_res_reg  <= '0;
            if (op_reg == OP_FILL) begin
                flat_res_reg <= idx_reg;
                bc_res_reg   <= bc_n;
                bw_res_reg   <= bw_n;
                bw2_res_reg  <= bw2_n;
            end else if (op_reg == OP_READ_BIN) begin
                st_res_reg <= status_reg;
                if (!status_reg) begin
                    flat_res_reg <= idx_reg;
                    bc_res_reg   <= rd_reg[31:0];
                    bw_res_reg   <= rd_reg[71:32];
                    bw2_res_reg  <= rd_reg[127:72];
                end
            end
        end
        if (cmd.result_load) begin
            m_data <= {gwyy_reg, gwy_reg, gwxx_reg, gwx_reg, gw2_reg, gw_reg, ent_reg,
                       bw2_res_reg, bw_res_reg, bc_res_reg,
                       12'(flat_res_reg), st_res_reg};
        end
    end
endmodule

// ===== rtl/core/weighted_2d_histogram_fill.sv =====
// weighted 2d histogram with underflow and overflow bins: top level
// Each beat passes from acceptance to the result register through load and
// axis multiply, bin index, table read, update and output; a new beat is accepted
// only when the controller is idle, so not before the last one is through, and while
// a result waits on m_tready the next item runs up to the output stage and holds
// there. After reset the bin table is cleared one entry per cycle, all
// (MAX_BINS_X+2)*(MAX_BINS_Y+2) entries, while s_tready stays low. The user must
// write the registers only while idle; the block itself does not enforce it.
`include "weighted_2d_histogram_fill_macros.svh"
module weighted_2d_histogram_fill
    import w2h_pkg::*;
#(
    parameter int MAX_BINS_X = 62,
    parameter int MAX_BINS_Y = 62
)(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, x_value, y_value, weight, read_bin_x, read_bin_y
    input  logic [63:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, flat_bin, bin_count, bin_weight_total, bin_weight_sq_total, entries,
    // weight_total, weight_sq_total, weighted_x_sum, weighted_x_sq_sum,
    // weighted_y_sum, weighted_y_sq_sum
    output logic [543:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int IDX_W = $clog2((MAX_BINS_X + 2) * (MAX_BINS_Y + 2));

    logic [15:0] x_lower_reg, x_upper_reg, y_lower_reg, y_upper_reg;
    logic [23:0] x_scale_reg, y_scale_reg;
    logic [5:0]  x_bins_reg, y_bins_reg;
    logic [540:0] res_data;
    w2h_cmd_t  cmd;
    w2h_stat_t stat;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_lower_reg <= 16'h8000;
            x_upper_reg <= 16'h7fff;
            x_scale_reg <= 24'd62;
            x_bins_reg  <= 6'd62;
            y_lower_reg <= 16'h8000;
            y_upper_reg <= 16'h7fff;
            y_scale_reg <= 24'd62;
            y_bins_reg  <= 6'd62;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            unique case (paddr[4:2])
                REG_X_LOWER: x_lower_reg <= pwdata[15:0];
                REG_X_UPPER: x_upper_reg <= pwdata[15:0];
                REG_X_SCALE: x_scale_reg <= pwdata[23:0];
                REG_X_BINS:  x_bins_reg  <= pwdata[5:0];
                REG_Y_LOWER: y_lower_reg <= pwdata[15:0];
                REG_Y_UPPER: y_upper_reg <= pwdata[15:0];
                REG_Y_SCALE: y_scale_reg <= pwdata[23:0];
                REG_Y_BINS:  y_bins_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_X_LOWER: prdata = {16'd0, x_lower_reg};
            REG_X_UPPER: prdata = {16'd0, x_upper_reg};
            REG_X_SCALE: prdata = {8'd0, x_scale_reg};
            REG_X_BINS:  prdata = {26'd0, x_bins_reg};
            REG_Y_LOWER: prdata = {16'd0, y_lower_reg};
            REG_Y_UPPER: prdata = {16'd0, y_upper_reg};
            REG_Y_SCALE: prdata = {8'd0, y_scale_reg};
            REG_Y_BINS:  prdata = {26'd0, y_bins_reg};
            default:     prdata = '0;
        endcase
    end

    w2h_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    w2h_datapath #(
        .MAX_BINS_X (MAX_BINS_X),
        .MAX_BINS_Y (MAX_BINS_Y),
        .IDX_W      (IDX_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_opcode (s_tdata[1:0]),
        .in_x      (s_tdata[17:2]),
        .in_y      (s_tdata[33:18]),
        .in_w      (s_tdata[49:34]),
        .in_rx     (s_tdata[55:50]),
        .in_ry     (s_tdata[61:56]),
        .x_lower   (x_lower_reg),
        .x_upper   (x_upper_reg),
        .x_scale   (x_scale_reg),
        .x_bins    (x_bins_reg),
        .y_lower   (y_lower_reg),
        .y_upper   (y_upper_reg),
        .y_scale   (y_scale_reg),
        .y_bins    (y_bins_reg),
        .m_data    (res_data)
    );

    assign m_tdata = {3'd0, res_data};

    `W2H_ASSERT_NXT(a_one_cmd, aclk, aresetn, 1'b1, $onehot0({cmd.load, cmd.bin_calc, cmd.mem_read, cmd.update, cmd.result_load}))
    `W2H_ASSERT_IMP(a_no_take_in_clear, aclk, aresetn, cmd.clear_en, !s_tready)
    `W2H_ASSERT_NXT(a_result_valid, aclk, aresetn, cmd.result_load, m_tvalid)
endmodule

// ===== verif/tb_top.sv =====
// testbench for the weighted 2d histogram: a scoreboard predicts every result beat
`timescale 1ns / 1ps
module tb_top;
    import w2h_pkg::*;

    localparam logic [1:0] OP_READ_GLOBAL = 2'd2;
    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam int         CYCLE_LIMIT    = 600000;

    typedef struct {
        logic [1:0]  opcode;
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic [15:0] weight;
        logic [5:0]  read_bin_x;
        logic [5:0]  read_bin_y;
    } hist_item_t;

    typedef struct {
        logic [0:0]  status;
        logic [11:0] flat_bin;
        logic [31:0] bin_count;
        logic [39:0] bin_weight_total;
        logic [55:0] bin_weight_sq_total;
        logic [31:0] entries;
        logic [47:0] weight_total;
        logic [63:0] weight_sq_total;
        logic [63:0] weighted_x_sum;
        logic [63:0] weighted_x_sq_sum;
        logic [63:0] weighted_y_sum;
        logic [63:0] weighted_y_sq_sum;
    } hist_result_t;

    class hist_scoreboard;
        logic signed [15:0] x_lower, x_upper, y_lower, y_upper;
        logic [23:0] x_scale, y_scale;
        logic [5:0]  x_bins, y_bins;
        logic [31:0] counts [4096];
        logic [39:0] wsums [4096];
        logic [55:0] wsqsums [4096];
        logic [31:0] entry_count;
        logic [47:0] gw;
        logic [63:0] gw2, gwx2, gwy2;
        logic signed [63:0] gwx, gwy;
        hist_result_t pending [$];
        int errors;

        function new();
            x_lower = -16'sd32768; x_upper = 16'sd32767; x_scale = 62; x_bins = 62;
            y_lower = -16'sd32768; y_upper = 16'sd32767; y_scale = 62; y_bins = 62;
            foreach (counts[i]) begin
                counts[i] = 0; wsums[i] = 0; wsqsums[i] = 0;
            end
            entry_count = 0; gw = 0; gw2 = 0; gwx = 0; gwx2 = 0; gwy = 0; gwy2 = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_X_LOWER: x_lower = val[15:0];
                REG_X_UPPER: x_upper = val[15:0];
                REG_X_SCALE: x_scale = val[23:0];
                REG_X_BINS:  x_bins  = val[5:0];
                REG_Y_LOWER: y_lower = val[15:0];
                REG_Y_UPPER: y_upper = val[15:0];
                REG_Y_SCALE: y_scale = val[23:0];
                default:     y_bins  = val[5:0];
            endcase
        endfunction

        function int clamp_bins(logic [5:0] r);
            if (r == 0) return 1;
            if (r > 62) return 62;
            return r;
        endfunction

        function int axis_bin(logic signed [15:0] v, logic signed [15:0] lo,
                              logic [23:0] sc, int nb);
            longint d, p, q;
            d = longint'(v) - longint'(lo);
            p = d * longint'({1'b0, sc});
            q = (p >>> 16) + 1;
            if (q < 0) q = 0;
            if (q > nb + 1) q = nb + 1;
            return int'(q);
        endfunction

        function logic [63:0] sat_u(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return (s > {1'b0, lim}) ? lim : s[63:0];
        endfunction

        function logic signed [63:0] sat_s(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return s[63:0];
        endfunction

        function void note_item(hist_item_t it);
            hist_result_t r;
            int nbx, nby, bx, by, idx;
            logic signed [63:0] sx, sy;
            logic [63:0] w, w2;
            nbx = clamp_bins(x_bins);
            nby = clamp_bins(y_bins);
            r.status = 0; r.flat_bin = 0; r.bin_count = 0;
            r.bin_weight_total = 0; r.bin_weight_sq_total = 0;
            if (it.opcode == OP_FILL) begin
                sx = 64'(signed'(it.x_value));
                sy = 64'(signed'(it.y_value));
                w = 64'(it.weight);
                w2 = w * w;
                bx = axis_bin(it.x_value, x_lower, x_scale, nbx);
                by = axis_bin(it.y_value, y_lower, y_scale, nby);
                idx = bx + (nbx + 2) * by;
                if (idx > 4095) idx = 4095;
                counts[idx] = sat_u(counts[idx], 1, 64'hFFFF_FFFF);
                wsums[idx] = sat_u(wsums[idx], w, 64'hFF_FFFF_FFFF);
                wsqsums[idx] = sat_u(wsqsums[idx], w2, 64'hFF_FFFF_FFFF_FFFF);
                if (signed'(it.x_value) >= x_lower && signed'(it.x_value) <= x_upper &&
                    signed'(it.y_value) >= y_lower && signed'(it.y_value) <= y_upper) begin
                    gwx = sat_s(gwx, sx * signed'(w));
                    gwx2 = sat_u(gwx2, (sx * sx) * w, '1);
                    gwy = sat_s(gwy, sy * signed'(w));
                    gwy2 = sat_u(gwy2, (sy * sy) * w, '1);
                    gw = sat_u(gw, w, 64'hFFFF_FFFF_FFFF);
                    gw2 = sat_u(gw2, w2, '1);
                end
                entry_count = sat_u(entry_count, 1, 64'hFFFF_FFFF);
                r.flat_bin = idx; r.bin_count = counts[idx];
                r.bin_weight_total = wsums[idx]; r.bin_weight_sq_total = wsqsums[idx];
            end else if (it.opcode == OP_READ_BIN) begin
                if (it.read_bin_x > nbx + 1 || it.read_bin_y > nby + 1) begin
                    r.status = 1;
                end else begin
                    idx = it.read_bin_x + (nbx + 2) * it.read_bin_y;
                    if (idx > 4095) idx = 4095;
                    r.flat_bin = idx; r.bin_count = counts[idx];
                    r.bin_weight_total = wsums[idx]; r.bin_weight_sq_total = wsqsums[idx];
                end
            end
            r.entries = entry_count; r.weight_total = gw; r.weight_sq_total = gw2;
            r.weighted_x_sum = gwx; r.weighted_x_sq_sum = gwx2;
            r.weighted_y_sum = gwy; r.weighted_y_sq_sum = gwy2;
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s: expected %h, got %h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(hist_result_t a);
            hist_result_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", e.status, a.status);
            cmp("flat_bin", e.flat_bin, a.flat_bin);
            cmp("bin_count", e.bin_count, a.bin_count);
            cmp("bin_weight_total", e.bin_weight_total, a.bin_weight_total);
            cmp("bin_weight_sq_total", e.bin_weight_sq_total, a.bin_weight_sq_total);
            cmp("entries", e.entries, a.entries);
            cmp("weight_total", e.weight_total, a.weight_total);
            cmp("weight_sq_total", e.weight_sq_total, a.weight_sq_total);
            cmp("weighted_x_sum", e.weighted_x_sum, a.weighted_x_sum);
            cmp("weighted_x_sq_sum", e.weighted_x_sq_sum, a.weighted_x_sq_sum);
            cmp("weighted_y_sum", e.weighted_y_sum, a.weighted_y_sum);
            cmp("weighted_y_sq_sum", e.weighted_y_sq_sum, a.weighted_y_sq_sum);
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [543:0] m_tdata;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    hist_scoreboard sb = new();
    int  cycles = 0;
    int  beats_out = 0;
    bit  send_burst = 0;
    bit  recv_burst = 0;
    bit  long_hold = 0;
    logic signed [15:0] cur_xl = -16'sd32768, cur_xu = 16'sd32767;
    logic signed [15:0] cur_yl = -16'sd32768, cur_yu = 16'sd32767;

    weighted_2d_histogram_fill u_top (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result side: unpack and check
    always @(posedge aclk) begin
        logic [543:0] v;
        hist_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            v = m_tdata;
            r.status = v[0];
            r.flat_bin = v[12:1];
            r.bin_count = v[44:13];
            r.bin_weight_total = v[84:45];
            r.bin_weight_sq_total = v[140:85];
            r.entries = v[172:141];
            r.weight_total = v[220:173];
            r.weight_sq_total = v[284:221];
            r.weighted_x_sum = v[348:285];
            r.weighted_x_sq_sum = v[412:349];
            r.weighted_y_sum = v[476:413];
            r.weighted_y_sq_sum = v[540:477];
            sb.check_result(r);
            beats_out <= beats_out + 1;
        end
    end

    // receiver stalls
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end
            gap = recv_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready) && !long_hold);
        end
    end

    task automatic send_item(hist_item_t it);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b0, it.read_bin_y, it.read_bin_x, it.weight,
                    it.y_value, it.x_value, it.opcode};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_axes(logic signed [15:0] xl, logic signed [15:0] xu,
                            logic [23:0] xs, logic [5:0] xb,
                            logic signed [15:0] yl, logic signed [15:0] yu,
                            logic [23:0] ys, logic [5:0] yb);
        drain();
        write_reg(REG_X_LOWER, 32'(xl)); write_reg(REG_X_UPPER, 32'(xu));
        write_reg(REG_X_SCALE, xs);      write_reg(REG_X_BINS, xb);
        write_reg(REG_Y_LOWER, 32'(yl)); write_reg(REG_Y_UPPER, 32'(yu));
        write_reg(REG_Y_SCALE, ys);      write_reg(REG_Y_BINS, yb);
        cur_xl = xl; cur_xu = xu; cur_yl = yl; cur_yu = yu;
    endtask

    function automatic logic [15:0] near_axis(logic signed [15:0] lo, logic signed [15:0] hi);
        int a, b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        a = (a - 40 < -32768) ? -32768 : a - 40;
        b = (b + 40 > 32767) ? 32767 : b + 40;
        return 16'($urandom_range(0, b - a) + a);
    endfunction

    function automatic hist_item_t fill_item(logic [15:0] x, logic [15:0] y, logic [15:0] w);
        hist_item_t it;
        it.opcode = OP_FILL; it.x_value = x; it.y_value = y; it.weight = w;
        it.read_bin_x = $urandom; it.read_bin_y = $urandom;
        return it;
    endfunction

    function automatic hist_item_t read_item(logic [1:0] op, logic [5:0] bx, logic [5:0] by);
        hist_item_t it;
        it.opcode = op; it.x_value = $urandom; it.y_value = $urandom;
        it.weight = $urandom; it.read_bin_x = bx; it.read_bin_y = by;
        return it;
    endfunction

    task automatic random_phase(int n);
        hist_item_t it;
        int k;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
                recv_burst = ($urandom_range(0, 3) == 0);
            end
            k = $urandom_range(0, 9);
            if (k < 6)
                it = fill_item(near_axis(cur_xl, cur_xu), near_axis(cur_yl, cur_yu), $urandom);
            else if (k == 6)
                it = fill_item($urandom, $urandom, $urandom);
            else if (k < 9)
                it = read_item(OP_READ_BIN, $urandom, $urandom);
            else
                it = read_item($urandom_range(2, 3), $urandom, $urandom);
            send_item(it);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, every operation, out of range reads
        send_item(fill_item(16'h8000, 16'h8000, 16'hFFFF));
        send_item(fill_item(16'h7FFF, 16'h7FFF, 16'hFFFF));
        send_item(fill_item(16'h7FFF, 16'h8000, 16'h0000));
        send_item(fill_item(16'h0000, 16'h0000, 16'h0100));
        send_item(fill_item(16'hFFFF, 16'h0001, 16'h0001));
        send_item(read_item(OP_READ_BIN, 0, 0));
        send_item(read_item(OP_READ_BIN, 63, 63));
        send_item(read_item(OP_READ_BIN, 63, 0));
        send_item(read_item(OP_READ_BIN, 0, 63));
        send_item(read_item(OP_READ_BIN, 62, 1));
        send_item(read_item(OP_READ_GLOBAL, 0, 0));
        send_item(read_item(OP_SPARE, 0, 0));

        // lower edge above upper edge, zero scale, bins zero
        set_axes(16'sd100, -16'sd100, 24'd0, 6'd0, 16'sd32767, -16'sd32768, 24'd0, 6'd0);
        send_item(fill_item(16'd0, 16'd0, 16'h0200));
        send_item(fill_item(16'h8000, 16'h8000, 16'h0200));
        send_item(fill_item(16'd200, 16'h7FFF, 16'hFFFF));
        send_item(read_item(OP_READ_BIN, 1, 1));
        send_item(read_item(OP_READ_BIN, 3, 0));

        // largest scale and bins beyond the maximum
        set_axes(-16'sd32768, 16'sd32767, 24'hFFFFFF, 6'd63,
                 16'sd0, 16'sd10, 24'hFFFFFF, 6'd1);
        send_item(fill_item(16'h8000, 16'd5, 16'h0100));
        send_item(fill_item(16'h8001, 16'hFFFF, 16'h0100));
        send_item(read_item(OP_READ_BIN, 63, 2));
        random_phase(60);

        set_axes(-16'sd100, 16'sd100, 24'd6554, 6'd20, -16'sd50, 16'sd50, 24'd13107, 6'd10);
        random_phase(150);

        // long receiver hold while the sender keeps pushing
        long_hold = 1;
        send_burst = 1;
        for (int i = 0; i < 20; i++)
            send_item(fill_item(near_axis(cur_xl, cur_xu), near_axis(cur_yl, cur_yu), $urandom));
        drain();

        set_axes(16'sd1000, 16'sd1030, 24'd131072, 6'd62, -16'sd3, 16'sd3, 24'd655360, 6'd62);
        random_phase(150);

        set_axes(-16'sd20000, 16'sd20000, 24'd100, 6'd1, -16'sd32768, 16'sd32767, 24'd62, 6'd62);
        random_phase(150);

        set_axes(-16'sd32768, 16'sd32767, 24'd62, 6'd62, -16'sd32768, 16'sd32767, 24'd62, 6'd62);
        random_phase(150);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
